// ===== rtl/cbe_pkg.sv =====
// Shared types, constants and fixed-point helpers for the cubic Bezier easing evaluator.
`timescale 1ns / 1ps
`default_nettype none
package cbe_pkg;

   localparam int FRAC  = 16;
   localparam int UX_W  = 17;
   localparam int SY_W  = 18;
   localparam int W     = 24;
   localparam int MW    = W + UX_W + 1;
   localparam int QW    = 18;
   localparam int IDX_W = 2;

   localparam logic [UX_W-1:0]        ONE_U   = UX_W'(1) << FRAC;
   localparam logic signed [W-1:0]    ONE_S   = W'(1) << FRAC;
   localparam logic signed [W-1:0]    Y_MAX   = (W'(2) << FRAC) - W'(1);
   localparam logic signed [W-1:0]    Y_MIN   = -(W'(2) << FRAC);

   typedef enum logic [IDX_W-1:0] {
      REG_X1 = 2'd0,
      REG_Y1 = 2'd1,
      REG_X2 = 2'd2,
      REG_Y2 = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic signed [W-1:0] ca;
      logic signed [W-1:0] cb;
      logic signed [W-1:0] cc;
      logic signed [W-1:0] ca3;
      logic signed [W-1:0] cb2;
      logic signed [W-1:0] ce;
      logic signed [W-1:0] cf;
      logic signed [W-1:0] cg;
   } coef_type;

   typedef struct packed {
      logic [UX_W-1:0] x;
      logic [UX_W-1:0] t;
      logic            flat;
   } item_type;

   typedef struct packed {
      logic [SY_W-1:0] y;
      logic            flat;
   } result_type;

   function automatic logic signed [MW-1:0] mul_t(logic signed [W-1:0] a, logic [UX_W-1:0] t);
      logic signed [UX_W:0] ts;
      ts = $signed({1'b0, t});
      mul_t = a * ts;
   endfunction

   // floor division by 2^FRAC
   function automatic logic signed [W-1:0] fx_trunc(logic signed [MW-1:0] p);
      fx_trunc = $signed(p[FRAC +: W]);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/cubic_bezier_easing_eval.sv =====
// Top level of the cubic Bezier easing evaluator: control registers, pipeline and output buffer.
//
// Takes one x per clock while req_tready is high and returns Y(t) after the input
// register, NEWTON_STEPS Newton steps, the Y evaluator and the output register; each
// Newton step is 27 stages, 18 of them a one-bit-per-stage restoring divider.
// Throughput is one transfer per cycle while not stalled. The output holds one waiting result
// plus one skid entry, so input is refused only when both are full. Control
// registers must be written while no transfer is in flight.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_easing_eval
   import cbe_pkg::*;
#(
   parameter int NEWTON_STEPS = 8
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wen,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [SY_W-1:0]   csr_wdata,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [23:0]       req_tdata,   // [16:0] x_in
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [23:0]            rsp_tdata,   // [17:0] y_out
   output logic                   rsp_tuser    // [0] flat_slope
);

   logic [UX_W-1:0] ctrl_x1_ff, ctrl_x2_ff;
   logic [SY_W-1:0] ctrl_y1_ff, ctrl_y2_ff;
   coef_type        coef_ff, coef_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_x1_ff <= '0;
         ctrl_y1_ff <= '0;
         ctrl_x2_ff <= ONE_U;
         ctrl_y2_ff <= SY_W'(ONE_U);
      end else if (csr_wen) begin
         case (reg_idx_type'(csr_index))
            REG_X1:  ctrl_x1_ff <= csr_wdata[UX_W-1:0];
            REG_Y1:  ctrl_y1_ff <= csr_wdata;
            REG_X2:  ctrl_x2_ff <= csr_wdata[UX_W-1:0];
            REG_Y2:  ctrl_y2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic signed [W-1:0] x1, x2, y1, y2, x13, x23, y13, y23;
      x1  = $signed({{(W-UX_W){1'b0}}, (ctrl_x1_ff > ONE_U) ? ONE_U : ctrl_x1_ff});
      x2  = $signed({{(W-UX_W){1'b0}}, (ctrl_x2_ff > ONE_U) ? ONE_U : ctrl_x2_ff});
      y1  = $signed({{(W-SY_W){ctrl_y1_ff[SY_W-1]}}, ctrl_y1_ff});
      y2  = $signed({{(W-SY_W){ctrl_y2_ff[SY_W-1]}}, ctrl_y2_ff});
      x13 = (x1 <<< 1) + x1;
      x23 = (x2 <<< 1) + x2;
      y13 = (y1 <<< 1) + y1;
      y23 = (y2 <<< 1) + y2;
      coef_in.ca  = ONE_S - x23 + x13;
      coef_in.cb  = x23 - (x13 <<< 1);
      coef_in.cc  = x13;
      coef_in.ca3 = (coef_in.ca <<< 1) + coef_in.ca;
      coef_in.cb2 = coef_in.cb <<< 1;
      coef_in.ce  = ONE_S - y23 + y13;
      coef_in.cf  = y23 - (y13 <<< 1);
      coef_in.cg  = y13;
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   logic       en;
   logic       in_v_ff, in_v_in;
   item_type   in_ff, in_in;
   logic       stg_v [0:NEWTON_STEPS];
   item_type   stg_d [0:NEWTON_STEPS];
   logic       y_v;
   result_type y_d;

   logic       rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   result_type rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_comb begin
      logic [UX_W-1:0] xs;
      xs         = (req_tdata[UX_W-1:0] > ONE_U) ? ONE_U : req_tdata[UX_W-1:0];
      in_v_in    = req_tvalid;
      in_in.x    = xs;
      in_in.t    = xs;
      in_in.flat = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= in_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= in_in;
      end
   end

   assign stg_v[0] = in_v_ff;
   assign stg_d[0] = in_ff;

   genvar s;
   generate
      for (s = 0; s < NEWTON_STEPS; s++) begin : g_step
         cbe_newton_step u_step (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .coef      (coef_ff),
            .in_valid  (stg_v[s]),
            .in_item   (stg_d[s]),
            .out_valid (stg_v[s+1]),
            .out_item  (stg_d[s+1])
         );
      end
   endgenerate

   cbe_y_eval u_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .coef      (coef_ff),
      .in_valid  (stg_v[NEWTON_STEPS]),
      .in_item   (stg_d[NEWTON_STEPS]),
      .out_valid (y_v),
      .out_res   (y_d)
   );

   always_comb begin
      logic take, pop;
      take          = y_v && en;
      pop           = rsp_valid_ff && rsp_tready;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = take;
            rsp_data_in   = y_d;
         end
      end else if (take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = y_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24-SY_W){1'b0}}, rsp_data_ff.y};
   assign rsp_tuser  = rsp_data_ff.flat;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a pending output");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(y_v) && $stable(y_d))
      else $error("pipeline moved while stalled");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !(rsp_valid_ff && rsp_tready) |=> skid_valid_ff && $stable(skid_data_ff))
      else $error("skid entry lost");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !skid_valid_ff)
      else $error("output not empty after reset");
`endif

endmodule
`default_nettype wire

// ===== rtl/cbe_newton_step.sv =====
// One pipelined Newton iteration: X(t), X'(t), bit-serial divide stages and clamped update.
`timescale 1ns / 1ps
`default_nettype none
module cbe_newton_step
   import cbe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire coef_type coef,
   input  wire logic     in_valid,
   input  wire item_type in_item,
   output logic          out_valid,
   output item_type      out_item
);

   localparam int NS = 7 + 1 + QW + 1;

   typedef struct packed {
      item_type                it;
      logic signed [MW-1:0]    px;
      logic signed [MW-1:0]    ps;
   } mm_type;

   typedef struct packed {
      item_type                it;
      logic signed [W-1:0]     ax;
      logic signed [W-1:0]     sl;
   } aa_type;

   typedef struct packed {
      item_type                it;
      logic signed [MW-1:0]    px;
      logic signed [W-1:0]     sl;
   } m5_type;

   typedef struct packed {
      item_type                it;
      logic signed [W-1:0]     diff;
      logic signed [W-1:0]     sl;
   } df_type;

   typedef struct packed {
      item_type                it;
      logic [W-1:0]            dmag;
      logic [W-1:0]            smag;
      logic                    neg;
      logic                    zero;
   } mg_type;

   typedef struct packed {
      item_type                it;
      logic [W-1:0]            dmag;
      logic [W-1:0]            smag;
      logic                    neg;
      logic                    zero;
      logic                    ovf;
      logic [W-1:0]            rem;
      logic [QW-1:0]           q;
   } dv_type;

   logic [NS-1:0] v_ff, v_in;
   mm_type   m1_ff, m1_in;
   aa_type   a2_ff, a2_in;
   mm_type   m3_ff, m3_in;
   aa_type   a4_ff, a4_in;
   m5_type   m5_ff, m5_in;
   df_type   s6_ff, s6_in;
   mg_type   s7_ff, s7_in;
   dv_type   dv_ff [0:QW];
   dv_type   dv_in [0:QW];
   item_type ap_ff, ap_in;

   assign v_in = {v_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      m1_in.it = in_item;
      m1_in.px = mul_t(coef.ca, in_item.t);
      m1_in.ps = mul_t(coef.ca3, in_item.t);

      a2_in.it = m1_ff.it;
      a2_in.ax = fx_trunc(m1_ff.px) + coef.cb;
      a2_in.sl = fx_trunc(m1_ff.ps) + coef.cb2;

      m3_in.it = a2_ff.it;
      m3_in.px = mul_t(a2_ff.ax, a2_ff.it.t);
      m3_in.ps = mul_t(a2_ff.sl, a2_ff.it.t);

      a4_in.it = m3_ff.it;
      a4_in.ax = fx_trunc(m3_ff.px) + coef.cc;
      a4_in.sl = fx_trunc(m3_ff.ps) + coef.cc;

      m5_in.it = a4_ff.it;
      m5_in.px = mul_t(a4_ff.ax, a4_ff.it.t);
      m5_in.sl = a4_ff.sl;

      s6_in.it   = m5_ff.it;
      s6_in.diff = fx_trunc(m5_ff.px) - $signed({{(W-UX_W){1'b0}}, m5_ff.it.x});
      s6_in.sl   = m5_ff.sl;

      s7_in.it   = s6_ff.it;
      s7_in.dmag = s6_ff.diff[W-1] ? W'(-s6_ff.diff) : W'(s6_ff.diff);
      s7_in.smag = s6_ff.sl[W-1] ? W'(-s6_ff.sl) : W'(s6_ff.sl);
      s7_in.neg  = s6_ff.diff[W-1] ^ s6_ff.sl[W-1];
      s7_in.zero = (s6_ff.sl == '0);

      // quotient needs QW bits unless |diff| >= 4*|slope|
      dv_in[0].it   = s7_ff.it;
      dv_in[0].dmag = s7_ff.dmag;
      dv_in[0].smag = s7_ff.smag;
      dv_in[0].neg  = s7_ff.neg;
      dv_in[0].zero = s7_ff.zero;
      dv_in[0].ovf  = ({2'b00, s7_ff.dmag} >= {s7_ff.smag, 2'b00});
      dv_in[0].rem  = s7_ff.dmag >> (QW - FRAC);
      dv_in[0].q    = '0;
   end

   genvar k;
   generate
      for (k = 1; k <= QW; k++) begin : g_div
         logic         nbit;
         logic [W:0]   rr;
         if (QW - k >= FRAC) begin : g_hi
            assign nbit = dv_ff[k-1].dmag[QW-k-FRAC];
         end else begin : g_lo
            assign nbit = 1'b0;
         end
         assign rr = {dv_ff[k-1].rem, nbit};
         always_comb begin
            dv_in[k] = dv_ff[k-1];
            if (rr >= {1'b0, dv_ff[k-1].smag}) begin
               dv_in[k].rem = W'(rr - {1'b0, dv_ff[k-1].smag});
               dv_in[k].q   = {dv_ff[k-1].q[QW-2:0], 1'b1};
            end else begin
               dv_in[k].rem = rr[W-1:0];
               dv_in[k].q   = {dv_ff[k-1].q[QW-2:0], 1'b0};
            end
         end
      end
   endgenerate

   always_comb begin
      logic [QW-1:0]          qv;
      logic signed [QW+1:0]   tw;
      logic signed [QW+1:0]   qw;
      logic signed [QW+1:0]   res;
      qv  = dv_ff[QW].ovf ? '1 : dv_ff[QW].q;
      tw  = $signed({{(QW+2-UX_W){1'b0}}, dv_ff[QW].it.t});
      qw  = $signed({2'b00, qv});
      res = dv_ff[QW].neg ? tw + qw : tw - qw;
      ap_in = dv_ff[QW].it;
      if (dv_ff[QW].zero) begin
         ap_in.flat = 1'b1;
      end else if (res < 0) begin
         ap_in.t = '0;
      end else if (res > $signed({{(QW+2-UX_W){1'b0}}, ONE_U})) begin
         ap_in.t = ONE_U;
      end else begin
         ap_in.t = res[UX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= m1_in;
         a2_ff <= a2_in;
         m3_ff <= m3_in;
         a4_ff <= a4_in;
         m5_ff <= m5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         for (int i = 0; i <= QW; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         ap_ff <= ap_in;
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_item  = ap_ff;

endmodule
`default_nettype wire

// ===== rtl/cbe_y_eval.sv =====
// Pipelined Horner evaluation of Y(t) with output saturation.
`timescale 1ns / 1ps
`default_nettype none
module cbe_y_eval
   import cbe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire coef_type coef,
   input  wire logic     in_valid,
   input  wire item_type in_item,
   output logic          out_valid,
   output result_type    out_res
);

   localparam int NS = 6;

   typedef struct packed {
      logic [UX_W-1:0]       t;
      logic                  flat;
      logic signed [MW-1:0]  p;
   } ym_type;

   typedef struct packed {
      logic [UX_W-1:0]       t;
      logic                  flat;
      logic signed [W-1:0]   a;
   } ya_type;

   logic [NS-1:0] v_ff, v_in;
   ym_type     m1_ff, m1_in, m3_ff, m3_in, m5_ff, m5_in;
   ya_type     a2_ff, a2_in, a4_ff, a4_in;
   result_type o_ff, o_in;

   assign v_in = {v_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      logic signed [W-1:0] yv;
      m1_in.t    = in_item.t;
      m1_in.flat = in_item.flat;
      m1_in.p    = mul_t(coef.ce, in_item.t);

      a2_in.t    = m1_ff.t;
      a2_in.flat = m1_ff.flat;
      a2_in.a    = fx_trunc(m1_ff.p) + coef.cf;

      m3_in.t    = a2_ff.t;
      m3_in.flat = a2_ff.flat;
      m3_in.p    = mul_t(a2_ff.a, a2_ff.t);

      a4_in.t    = m3_ff.t;
      a4_in.flat = m3_ff.flat;
      a4_in.a    = fx_trunc(m3_ff.p) + coef.cg;

      m5_in.t    = a4_ff.t;
      m5_in.flat = a4_ff.flat;
      m5_in.p    = mul_t(a4_ff.a, a4_ff.t);

      yv = fx_trunc(m5_ff.p);
      o_in.flat = m5_ff.flat;
      if (yv > Y_MAX) begin
         o_in.y = Y_MAX[SY_W-1:0];
      end else if (yv < Y_MIN) begin
         o_in.y = Y_MIN[SY_W-1:0];
      end else begin
         o_in.y = yv[SY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= m1_in;
         a2_ff <= a2_in;
         m3_ff <= m3_in;
         a4_ff <= a4_in;
         m5_ff <= m5_in;
         o_ff  <= o_in;
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_res   = o_ff;

endmodule
`default_nettype wire

// ===== tb/sv/tb_cubic_bezier_easing_eval.sv =====
// Testbench for cubic_bezier_easing_eval: directed table and random stimulus with a predictor.
`timescale 1ns / 1ps
module tb_cubic_bezier_easing_eval;
   import cbe_pkg::*;

   localparam longint UNIT = 65536;
   localparam int WDOG_LIMIT = 5000;

   typedef struct {
      logic [16:0] x;
      bit          typed;
      logic [17:0] y;
      logic        flat;
   } row_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wen = 0;
   logic [1:0]  csr_index = REG_X1;
   logic [17:0] csr_wdata = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;

   logic [16:0] sh_x1 = 17'd0;
   logic [17:0] sh_y1 = 18'd0;
   logic [16:0] sh_x2 = 17'd65536;
   logic [17:0] sh_y2 = 18'd65536;

   typedef struct {
      logic [17:0] y;
      logic        flat;
   } exp_t;

   exp_t pending_q[$];
   int   err_cnt = 0;
   int   idle_cycles = 0;
   bit   quiet = 0;
   int   stall_cnt = 0;

   cubic_bezier_easing_eval i_dut (
      .clock(clock), .reset(reset),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic longint unit_clip(logic [16:0] v);
      return (longint'(v) > UNIT) ? UNIT : longint'(v);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic longint horner3(longint a, longint b, longint c, longint t);
      return qmul(qmul(qmul(a, t) + b, t) + c, t);
   endfunction

   function automatic exp_t ease_predict(logic [16:0] xin);
      longint x1, x2, y1, y2, x, ca, cb, cc, ce, cf, cg, t, xt, slope, y;
      exp_t r;
      x1 = unit_clip(sh_x1);
      x2 = unit_clip(sh_x2);
      y1 = longint'($signed(sh_y1));
      y2 = longint'($signed(sh_y2));
      x  = unit_clip(xin);
      ca = UNIT - 3 * x2 + 3 * x1;
      cb = 3 * x2 - 6 * x1;
      cc = 3 * x1;
      ce = UNIT - 3 * y2 + 3 * y1;
      cf = 3 * y2 - 6 * y1;
      cg = 3 * y1;
      t = x;
      r.flat = 0;
      for (int i = 0; i < 8; i++) begin
         xt = horner3(ca, cb, cc, t);
         slope = qmul(qmul(3 * ca, t) + 2 * cb, t) + cc;
         if (slope == 0) begin
            r.flat = 1;
         end else begin
            t = t - ((xt - x) * UNIT) / slope;
            if (t < 0) t = 0;
            if (t > UNIT) t = UNIT;
         end
      end
      y = horner3(ce, cf, cg, t);
      if (y > 2 * UNIT - 1) y = 2 * UNIT - 1;
      if (y < -2 * UNIT) y = -2 * UNIT;
      r.y = y[17:0];
      return r;
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      if (stall_cnt > 0) stall_cnt--;
      if (stall_cnt == 0 && !quiet && !reset && $urandom_range(0, 7) == 0)
         stall_cnt = $urandom_range(1, 10);
      rsp_tready <= (stall_cnt == 0) && !reset;
   end

   // result check and watchdog
   always @(posedge clock) begin
      exp_t e;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Simulation FAILED");
            $finish;
         end
      end
      if (rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected transfer y=%h flat=%b", $time, rsp_tdata[17:0],
                     rsp_tuser);
            err_cnt++;
         end else begin
            e = pending_q.pop_front();
            if (rsp_tdata[17:0] !== e.y) begin
               $display("%0t: y_out exp %h got %h", $time, e.y, rsp_tdata[17:0]);
               err_cnt++;
            end
            if (rsp_tuser !== e.flat) begin
               $display("%0t: flat_slope exp %b got %b", $time, e.flat, rsp_tuser);
               err_cnt++;
            end
         end
      end
   end

   task automatic send_x(logic [16:0] x, bit typed = 0, logic [17:0] ty = 0,
                         logic tf = 0);
      exp_t e;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {7'd0, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (typed) begin
         e.y = ty;
         e.flat = tf;
      end else begin
         e = ease_predict(x);
      end
      pending_q.push_back(e);
   endtask

   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_curve(logic [17:0] x1, logic [17:0] y1, logic [17:0] x2,
                              logic [17:0] y2);
      logic [17:0] vals[4];
      vals = '{x1, y1, x2, y2};
      for (int i = 0; i < 4; i++) begin
         csr_wen   <= 1;
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wen <= 0;
      sh_x1 = x1[16:0];
      sh_y1 = y1;
      sh_x2 = x2[16:0];
      sh_y2 = y2;
   endtask

   function automatic logic [16:0] rand_x();
      case ($urandom_range(0, 9))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [17:0] rand_cx();
      case ($urandom_range(0, 5))
         0: return 18'd0;
         1: return 18'd65536;
         2: return 18'($urandom_range(65537, 262143));
         default: return 18'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [17:0] rand_cy();
      case ($urandom_range(0, 5))
         0: return 18'h1FFFF;
         1: return 18'h20000;
         default: return 18'($urandom);
      endcase
   endfunction

   row_t dir_rows[] = '{
      '{17'd0,      1, 18'd0,     1'b1},
      '{17'd65536,  1, 18'd65536, 1'b1},
      '{17'd131071, 1, 18'd65536, 1'b1},
      '{17'd65537,  1, 18'd65536, 1'b1},
      '{17'd1,      0, 18'd0,     1'b0},
      '{17'd32768,  0, 18'd0,     1'b0},
      '{17'd16384,  0, 18'd0,     1'b0},
      '{17'd49152,  0, 18'd0,     1'b0},
      '{17'd65535,  0, 18'd0,     1'b0},
      '{17'd21845,  0, 18'd0,     1'b0},
      '{17'h0AAAA,  0, 18'd0,     1'b0},
      '{17'h15555,  0, 18'd0,     1'b0}
   };

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (dir_rows[i])
         send_x(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].y, dir_rows[i].flat);
      drain();
      // extreme curves
      write_curve(18'd0, 18'h1FFFF, 18'd0, 18'h20000);
      foreach (dir_rows[i]) send_x(dir_rows[i].x);
      drain();
      write_curve(18'd65536, 18'h20000, 18'd65536, 18'h1FFFF);
      foreach (dir_rows[i]) send_x(dir_rows[i].x);
      drain();
      write_curve(18'h3FFFF, 18'd0, 18'h3FFFF, 18'd65536);
      foreach (dir_rows[i]) send_x(dir_rows[i].x);
      drain();
      for (int p = 0; p < 8; p++) begin
         if (p == 7) quiet = 1;
         write_curve(rand_cx(), rand_cy(), rand_cx(), rand_cy());
         for (int n = 0; n < 85; n++) begin
            send_x(rand_x());
            if (p == 3 && n == 40) drain();
         end
         drain();
      end
      repeat (250) @(posedge clock);
      if (err_cnt == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== cubic_bezier_easing_eval.f =====
rtl/cbe_pkg.sv
rtl/cbe_newton_step.sv
rtl/cbe_y_eval.sv
rtl/cubic_bezier_easing_eval.sv
tb/sv/tb_cubic_bezier_easing_eval.sv
